// ----- hdl/wshs_pkg.sv -----
// Shared types and codes for the wake session handshake controller.
`timescale 1ns / 1ps

package wshs_pkg;

   typedef enum logic [1:0] {
      OP_TICK  = 2'd0,
      OP_START = 2'd1,
      OP_FRAME = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      FT_CONFIRM = 2'd0,
      FT_STANDBY = 2'd1,
      FT_END     = 2'd2,
      FT_OTHER   = 2'd3
   } frame_kind_type;

   typedef enum logic [2:0] {
      PH_IDLE      = 3'd0,
      PH_HANDSHAKE = 3'd1,
      PH_WORK      = 3'd2,
      PH_GRACE     = 3'd3,
      PH_ENDING    = 3'd4
   } phase_type;

   typedef enum logic [2:0] {
      ACT_WAKE_ACK    = 3'd0,
      ACT_STANDBY_ACK = 3'd1,
      ACT_END         = 3'd2,
      ACT_SAMPLE      = 3'd3,
      ACT_FINISH      = 3'd4
   } action_type;

   typedef enum logic [2:0] {
      OUT_COMPLETED = 3'd0,
      OUT_CANCELLED = 3'd1,
      OUT_TIMEOUT   = 3'd2,
      OUT_WIRELESS  = 3'd3,
      OUT_NONE      = 3'd4
   } outcome_type;

   typedef enum logic [2:0] {
      REG_HOST_MAC       = 3'd0,
      REG_CONFIRM_TMO    = 3'd1,
      REG_WAKE_ACK_PER   = 3'd2,
      REG_GRACE          = 3'd3,
      REG_STANDBY_PER    = 3'd4,
      REG_WORK           = 3'd5,
      REG_SAMPLE_INT     = 3'd6,
      REG_REPEAT_GAP     = 3'd7
   } reg_index_type;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = 2;
   localparam int QUEUE_CW    = 3;
   localparam int MAX_RESULTS = 3;

   // Packed from the lowest bit up: peer_mac, sess_num, peer_added,
   // frame_valid, frame_type.
   typedef struct packed {
      logic [1:0]  frame_type;
      logic        frame_valid;
      logic        peer_added;
      logic [31:0] sess_num;
      logic [47:0] peer_mac;
   } req_item_type;

   typedef struct packed {
      logic [1:0]                    count;
      logic [31:0]                   session;
      logic [MAX_RESULTS-1:0][2:0]   act;
      logic [MAX_RESULTS-1:0][1:0]   outc;
   } rsp_bundle_type;

endpackage

// ----- hdl/wshs_front.sv -----
// Front end: configuration, session state machine, result bundle per item that yields results.
`timescale 1ns / 1ps

module wshs_front
   import wshs_pkg::*;
#(
   parameter int TIMER_WIDTH = 16
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           csr_valid,
   input  logic [2:0]     csr_index,
   input  logic [47:0]    csr_data,
   input  logic           in_valid,
   output logic           in_ready,
   input  logic [1:0]     in_op,
   input  req_item_type   in_item,
   input  logic           q_full,
   output logic           q_push,
   output rsp_bundle_type q_data
);

   localparam int CW = (TIMER_WIDTH > 16) ? TIMER_WIDTH : 16;

   function automatic logic [TIMER_WIDTH-1:0] bump(input logic [TIMER_WIDTH-1:0] t);
      return (t != '1) ? t + TIMER_WIDTH'(1) : t;
   endfunction

   logic [47:0] host_mac_ff;
   logic [15:0] confirm_ff, wake_per_ff, grace_ff, standby_per_ff, work_ff, sample_ff;
   logic [7:0]  rgap_ff;

   phase_type               phase_ff, phase_in;
   logic [31:0]             sess_ff, sess_in;
   logic [TIMER_WIDTH-1:0]  pt_ff, pt_in, per_ff, per_in;
   logic [1:0]              kind_ff, kind_in, left_ff, left_in;
   logic [7:0]              gap_ff, gap_in;
   outcome_type             pend_ff, pend_in;

   logic                    acc;
   logic [TIMER_WIDTH-1:0]  pt_b, per_b;
   logic [7:0]              gap_b;
   logic [15:0]             limit, period;
   logic [1:0]              per_kind;
   logic                    timed, expire, burst_fire, period_fire, start_ok, match;
   logic [1:0]              left_after;
   logic [1:0]              n;
   logic [MAX_RESULTS-1:0][2:0] act;
   logic [MAX_RESULTS-1:0][1:0] outc;

   assign in_ready = !q_full;
   assign acc      = in_valid && !q_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         host_mac_ff    <= '0;
         confirm_ff     <= 16'd3000;
         wake_per_ff    <= 16'd200;
         grace_ff       <= 16'd1000;
         standby_per_ff <= 16'd150;
         work_ff        <= 16'd10000;
         sample_ff      <= 16'd100;
         rgap_ff        <= 8'd30;
      end else if (csr_valid) begin
         case (csr_index)
            REG_HOST_MAC:     host_mac_ff    <= csr_data;
            REG_CONFIRM_TMO:  confirm_ff     <= csr_data[15:0];
            REG_WAKE_ACK_PER: wake_per_ff    <= csr_data[15:0];
            REG_GRACE:        grace_ff       <= csr_data[15:0];
            REG_STANDBY_PER:  standby_per_ff <= csr_data[15:0];
            REG_WORK:         work_ff        <= csr_data[15:0];
            REG_SAMPLE_INT:   sample_ff      <= csr_data[15:0];
            REG_REPEAT_GAP:   rgap_ff        <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   // Decisions shared by next-state and output logic.
   always_comb begin
      pt_b  = bump(pt_ff);
      per_b = bump(per_ff);
      gap_b = (gap_ff != 8'hFF) ? gap_ff + 8'd1 : gap_ff;
      case (phase_ff)
         PH_HANDSHAKE: begin
            limit = confirm_ff; period = wake_per_ff; per_kind = 2'(ACT_WAKE_ACK);
         end
         PH_WORK: begin
            limit = work_ff; period = sample_ff; per_kind = 2'(ACT_WAKE_ACK);
         end
         PH_GRACE: begin
            limit = grace_ff; period = standby_per_ff; per_kind = 2'(ACT_STANDBY_ACK);
         end
         default: begin
            limit = confirm_ff; period = wake_per_ff; per_kind = 2'(ACT_WAKE_ACK);
         end
      endcase
      timed       = phase_ff inside {PH_HANDSHAKE, PH_WORK, PH_GRACE};
      expire      = timed && (CW'(pt_b) >= CW'(limit));
      period_fire = CW'(per_b) >= CW'(period);
      burst_fire  = (left_ff != 2'd0) && (gap_b >= rgap_ff);
      left_after  = burst_fire ? left_ff - 2'd1 : left_ff;
      start_ok    = (in_item.peer_mac == host_mac_ff) && (in_item.sess_num != 32'd0)
                    && in_item.peer_added;
      match       = in_item.frame_valid && (in_item.peer_mac == host_mac_ff)
                    && (in_item.sess_num == sess_ff);
   end

   // Next state.
   always_comb begin
      phase_in = phase_ff;
      sess_in  = sess_ff;
      pt_in    = pt_ff;
      per_in   = per_ff;
      kind_in  = kind_ff;
      left_in  = left_ff;
      gap_in   = gap_ff;
      pend_in  = pend_ff;
      if (acc) begin
         case (in_op)
            OP_TICK: begin
               if (timed) begin
                  pt_in = pt_b;
                  if (expire) begin
                     if (phase_ff == PH_WORK) begin
                        phase_in = PH_ENDING;
                        pend_in  = OUT_COMPLETED;
                        kind_in  = 2'(ACT_END);
                        left_in  = 2'd2;
                        gap_in   = '0;
                     end else begin
                        phase_in = PH_IDLE;
                        left_in  = '0;
                        gap_in   = '0;
                        pend_in  = OUT_NONE;
                     end
                  end else begin
                     if (left_ff != 2'd0) begin
                        gap_in  = burst_fire ? 8'd0 : gap_b;
                        left_in = left_after;
                     end
                     per_in = period_fire ? '0 : per_b;
                     if (period_fire && phase_ff != PH_WORK) begin
                        kind_in = per_kind;
                        left_in = 2'd1;
                        gap_in  = '0;
                     end
                  end
               end else if (phase_ff == PH_ENDING) begin
                  if (left_ff != 2'd0) begin
                     gap_in  = burst_fire ? 8'd0 : gap_b;
                     left_in = left_after;
                  end
                  if (left_after == 2'd0) begin
                     phase_in = PH_IDLE;
                     left_in  = '0;
                     gap_in   = '0;
                     pend_in  = OUT_NONE;
                  end
               end
            end
            OP_START: begin
               if (phase_ff == PH_IDLE) begin
                  sess_in = in_item.sess_num;
                  if (!start_ok) begin
                     left_in = '0;
                     gap_in  = '0;
                     pend_in = OUT_NONE;
                  end else begin
                     phase_in = PH_HANDSHAKE;
                     pt_in    = '0;
                     per_in   = '0;
                     pend_in  = OUT_NONE;
                     kind_in  = 2'(ACT_WAKE_ACK);
                     left_in  = 2'd1;
                     gap_in   = '0;
                  end
               end
            end
            OP_FRAME: begin
               if (match && (phase_ff == PH_HANDSHAKE || phase_ff == PH_WORK)) begin
                  if (in_item.frame_type == FT_CONFIRM && phase_ff == PH_HANDSHAKE) begin
                     phase_in = PH_WORK;
                     pt_in    = '0;
                     per_in   = '0;
                  end else if (in_item.frame_type == FT_STANDBY) begin
                     phase_in = PH_GRACE;
                     pend_in  = (phase_ff == PH_HANDSHAKE) ? OUT_CANCELLED : OUT_COMPLETED;
                     pt_in    = '0;
                     per_in   = '0;
                     kind_in  = 2'(ACT_STANDBY_ACK);
                     left_in  = 2'd1;
                     gap_in   = '0;
                  end else if (in_item.frame_type == FT_END) begin
                     phase_in = PH_ENDING;
                     pend_in  = (phase_ff == PH_HANDSHAKE) ? OUT_CANCELLED : OUT_COMPLETED;
                     kind_in  = 2'(ACT_END);
                     left_in  = 2'd2;
                     gap_in   = '0;
                  end
               end else if (match && phase_ff == PH_GRACE
                            && in_item.frame_type == FT_STANDBY) begin
                  per_in  = '0;
                  kind_in = 2'(ACT_STANDBY_ACK);
                  left_in = 2'd1;
                  gap_in  = '0;
               end
            end
            default: ;
         endcase
      end
   end

   // Results of the accepted item.
   always_comb begin
      n    = '0;
      act  = '0;
      outc = '0;
      if (acc) begin
         case (in_op)
            OP_TICK: begin
               if (timed) begin
                  if (expire) begin
                     if (phase_ff == PH_WORK) begin
                        act[n] = ACT_END;
                     end else begin
                        act[n]  = ACT_FINISH;
                        outc[n] = (phase_ff == PH_HANDSHAKE) ? 2'(OUT_TIMEOUT)
                                                             : pend_ff[1:0];
                     end
                     n = n + 2'd1;
                  end else begin
                     if (burst_fire) begin
                        act[n] = {1'b0, kind_ff};
                        n = n + 2'd1;
                     end
                     if (period_fire) begin
                        act[n] = (phase_ff == PH_WORK) ? ACT_SAMPLE : {1'b0, per_kind};
                        n = n + 2'd1;
                     end
                  end
               end else if (phase_ff == PH_ENDING) begin
                  if (burst_fire) begin
                     act[n] = {1'b0, kind_ff};
                     n = n + 2'd1;
                  end
                  if (left_after == 2'd0) begin
                     act[n]  = ACT_FINISH;
                     outc[n] = pend_ff[1:0];
                     n = n + 2'd1;
                  end
               end
            end
            OP_START: begin
               if (phase_ff == PH_IDLE) begin
                  if (!start_ok) begin
                     act[0]  = ACT_FINISH;
                     outc[0] = 2'(OUT_WIRELESS);
                  end else begin
                     act[0] = ACT_WAKE_ACK;
                  end
                  n = 2'd1;
               end
            end
            OP_FRAME: begin
               if (match) begin
                  case (phase_ff)
                     PH_HANDSHAKE: begin
                        case (in_item.frame_type)
                           FT_CONFIRM: begin act[0] = ACT_SAMPLE;      n = 2'd1; end
                           FT_STANDBY: begin act[0] = ACT_STANDBY_ACK; n = 2'd1; end
                           FT_END:     begin act[0] = ACT_END;         n = 2'd1; end
                           default: ;
                        endcase
                     end
                     PH_WORK: begin
                        case (in_item.frame_type)
                           FT_STANDBY: begin act[0] = ACT_STANDBY_ACK; n = 2'd1; end
                           FT_END:     begin act[0] = ACT_END;         n = 2'd1; end
                           default: ;
                        endcase
                     end
                     PH_GRACE: begin
                        if (in_item.frame_type == FT_STANDBY) begin
                           act[0] = ACT_STANDBY_ACK;
                           n = 2'd1;
                        end
                     end
                     default: ;
                  endcase
               end
            end
            default: ;
         endcase
      end
      q_data.count   = n;
      q_data.session = sess_in;
      q_data.act     = act;
      q_data.outc    = outc;
      q_push         = acc && (n != 2'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         sess_ff  <= '0;
         pt_ff    <= '0;
         per_ff   <= '0;
         kind_ff  <= '0;
         left_ff  <= '0;
         gap_ff   <= '0;
         pend_ff  <= OUT_NONE;
      end else begin
         phase_ff <= phase_in;
         sess_ff  <= sess_in;
         pt_ff    <= pt_in;
         per_ff   <= per_in;
         kind_ff  <= kind_in;
         left_ff  <= left_in;
         gap_ff   <= gap_in;
         pend_ff  <= pend_in;
      end
   end

endmodule

// ----- hdl/wshs_fifo.sv -----
// Short queue of result bundles between front and back end.
`timescale 1ns / 1ps

module wshs_fifo
   import wshs_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  rsp_bundle_type wr_data,
   input  logic           pop,
   output rsp_bundle_type head,
   output logic           full,
   output logic           empty
);

   rsp_bundle_type        mem_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CW-1:0]   cnt_ff, cnt_in;

   assign full  = (cnt_ff == QUEUE_CW'(QUEUE_DEPTH));
   assign empty = (cnt_ff == '0);
   assign head  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QUEUE_AW'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + QUEUE_AW'(1) : rd_ptr_ff;
      cnt_in    = cnt_ff + QUEUE_CW'(push) - QUEUE_CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

// ----- hdl/wshs_back.sv -----
// Back end: send the results of each queued bundle one item at a time.
`timescale 1ns / 1ps

module wshs_back
   import wshs_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  rsp_bundle_type head,
   input  logic           empty,
   output logic           pop,
   output logic           out_valid,
   input  logic           out_ready,
   output logic [2:0]     out_action,
   output logic [31:0]    out_session,
   output logic [1:0]     out_outcome,
   output logic           out_last
);

   logic [1:0] idx_ff, idx_in;
   logic       fire;

   always_comb begin
      out_valid   = !empty;
      out_action  = head.act[idx_ff];
      out_outcome = head.outc[idx_ff];
      out_session = head.session;
      out_last    = (idx_ff == head.count - 2'd1);
      fire        = out_valid && out_ready;
      pop         = fire && out_last;
      idx_in      = fire ? (out_last ? 2'd0 : idx_ff + 2'd1) : idx_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else begin
         idx_ff <= idx_in;
      end
   end

endmodule

// ----- hdl/wake_session_handshake_fsm_top.sv -----
// Top level of the slave-side wake session handshake controller.
//
//  channel  | direction | handshake             | payload
//  req_     | in        | req_tvalid/req_tready | tdata events, tuser operation
//  rsp_     | out       | rsp_tvalid/rsp_tready | tdata session/outcome, tuser action
//  csr_     | in        | csr_valid/csr_ready   | csr_index, csr_data
//
// An item is taken whenever the result queue has room; it yields zero to two
// results, sent one per cycle from the queue head while rsp_tready is high.
// Results appear on rsp_ in the cycle after the item at the earliest.
// Synchronous active-high reset clears state and queue and loads configuration defaults.
// req_tready drops only while the four-entry result queue is full.
`timescale 1ns / 1ps

module wake_session_handshake_fsm_top
   import wshs_pkg::*;
#(
   parameter int TIMER_WIDTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [87:0] req_tdata,  // peer_mac, sess_num, peer_added, frame_valid, frame_type
   input  logic [1:0]  req_tuser,  // operation
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,  // out_session, outcome
   output logic [2:0]  rsp_tuser,  // action
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [47:0] csr_data
);

   req_item_type   item;
   rsp_bundle_type q_wr, q_head;
   logic           q_push, q_pop, q_full, q_empty;
   logic [31:0]    session;
   logic [1:0]     outcome;

   assign item      = req_item_type'(req_tdata[83:0]);
   assign csr_ready = 1'b1;
   assign rsp_tdata = {6'b0, outcome, session};

   wshs_front #(
      .TIMER_WIDTH(TIMER_WIDTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_op     (req_tuser),
      .in_item   (item),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_data    (q_wr)
   );

   wshs_fifo u_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .wr_data (q_wr),
      .pop     (q_pop),
      .head    (q_head),
      .full    (q_full),
      .empty   (q_empty)
   );

   wshs_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (q_head),
      .empty       (q_empty),
      .pop         (q_pop),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_action  (rsp_tuser),
      .out_session (session),
      .out_outcome (outcome),
      .out_last    (rsp_tlast)
   );

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_outcome_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser != ACT_FINISH) |-> (outcome == 2'd0))
      else $error("outcome set on a non-finish result");

   a_finish_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser == ACT_FINISH) |-> rsp_tlast)
      else $error("finish result not marked last");

endmodule
